/* rtl/i2cm_pkg.sv */
// i2cm_pkg: shared types, codes and helpers of the i2c master bit engine
package i2cm_pkg;

	// command codes on the op field
	localparam logic [2:0] OP_NONE     = 3'd0;
	localparam logic [2:0] OP_START    = 3'd1;
	localparam logic [2:0] OP_STOP     = 3'd2;
	localparam logic [2:0] OP_WRITE    = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;
	localparam logic [2:0] OP_WAIT_ACK = 3'd5;

	// configuration register indexes
	localparam logic CFG_TICKS_PER_US = 1'b0;
	localparam logic CFG_ACK_TIMEOUT  = 1'b1;

	localparam logic [7:0]  TICKS_PER_US_RST = 8'd1;
	localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd250;

	// hold lengths as a shift of ticks_per_us
	localparam logic [1:0] HOLD_1US = 2'd0;
	localparam logic [1:0] HOLD_2US = 2'd1;
	localparam logic [1:0] HOLD_4US = 2'd2;

	typedef enum logic [21:0] {
		PH_IDLE = 22'h000001,
		PH_ST1  = 22'h000002,
		PH_ST2  = 22'h000004,
		PH_ST3  = 22'h000008,
		PH_ST4  = 22'h000010,
		PH_SP1  = 22'h000020,
		PH_SP2  = 22'h000040,
		PH_SP3  = 22'h000080,
		PH_SP4  = 22'h000100,
		PH_WR0  = 22'h000200,
		PH_WR1  = 22'h000400,
		PH_WR2  = 22'h000800,
		PH_WR3  = 22'h001000,
		PH_RD1  = 22'h002000,
		PH_RD2  = 22'h004000,
		PH_AK1  = 22'h008000,
		PH_AK2  = 22'h010000,
		PH_AK3  = 22'h020000,
		PH_AK4  = 22'h040000,
		PH_WA1  = 22'h080000,
		PH_WA2  = 22'h100000,
		PH_WA3  = 22'h200000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  bit_index;
		logic [7:0]  shift_byte;
		logic [10:0] delay_left;
		logic [15:0] poll_count;
		logic        scl;
		logic        sda;
		logic        sda_oe;
		logic        ack_choice;
		logic        fail_pending;
		logic [7:0]  rx_byte;
	} state_t;

	localparam state_t STATE_RST = '{
		phase:        PH_IDLE,
		bit_index:    4'd0,
		shift_byte:   8'd0,
		delay_left:   11'd0,
		poll_count:   16'd0,
		scl:          1'b1,
		sda:          1'b1,
		sda_oe:       1'b1,
		ack_choice:   1'b0,
		fail_pending: 1'b0,
		rx_byte:      8'd0
	};

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_driving;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_failed;
	} res_t;

	// ticks left after the first one of an n microsecond hold
	function automatic logic [10:0] hold_delay(input logic [1:0] shamt, input logic [7:0] tpu);
		logic [9:0] t;
		t = 10'(tpu) << shamt;
		hold_delay = (t == 10'd0) ? 11'd0 : 11'(t - 10'd1);
	endfunction

endpackage

/* rtl/i2cm_step.sv */
// i2cm_step: next bus state and result word for one tick
module i2cm_step import i2cm_pkg::*; (
	input  state_t      cur,
	input  logic [7:0]  ticks_per_us,
	input  logic [15:0] ack_timeout,
	input  logic [2:0]  op,
	input  logic [7:0]  write_data,
	input  logic        send_ack,
	input  logic        sda_in,
	output state_t      nxt,
	output res_t        res
);

	function automatic state_t apply(input state_t st, input phase_t p, input logic [7:0] tpu);
		state_t s;
		s = st;
		s.phase = p;
		s.delay_left = 11'd0;
		case (p)
			PH_ST1: begin s.sda_oe = 1'b1; s.sda = 1'b1; end
			PH_ST2: s.scl = 1'b1;
			PH_ST3: begin s.sda = 1'b0; s.delay_left = hold_delay(HOLD_4US, tpu); end
			PH_ST4: s.scl = 1'b0;
			PH_SP1: begin s.sda_oe = 1'b1; s.scl = 1'b0; end
			PH_SP2: begin s.sda = 1'b0; s.delay_left = hold_delay(HOLD_4US, tpu); end
			PH_SP3: begin s.scl = 1'b1; s.delay_left = hold_delay(HOLD_4US, tpu); end
			PH_SP4: begin s.sda = 1'b1; s.delay_left = hold_delay(HOLD_4US, tpu); end
			PH_WR0: begin s.sda_oe = 1'b1; s.scl = 1'b0; end
			PH_WR1: begin
				s.sda = st.shift_byte[7];
				s.shift_byte = {st.shift_byte[6:0], 1'b0};
				s.delay_left = hold_delay(HOLD_2US, tpu);
			end
			PH_WR2: begin s.scl = 1'b1; s.delay_left = hold_delay(HOLD_2US, tpu); end
			PH_WR3: begin
				s.scl = 1'b0;
				s.bit_index = st.bit_index + 4'd1;
				s.delay_left = hold_delay(HOLD_2US, tpu);
			end
			PH_RD1: begin
				s.sda_oe = 1'b0;
				s.scl = 1'b0;
				s.delay_left = hold_delay(HOLD_2US, tpu);
			end
			PH_RD2: begin s.scl = 1'b1; s.delay_left = hold_delay(HOLD_1US, tpu); end
			PH_AK1: s.scl = 1'b0;
			PH_AK2: begin
				s.sda_oe = 1'b1;
				s.sda = ~st.ack_choice;
				s.delay_left = hold_delay(HOLD_2US, tpu);
			end
			PH_AK3: begin s.scl = 1'b1; s.delay_left = hold_delay(HOLD_2US, tpu); end
			PH_AK4: s.scl = 1'b0;
			PH_WA1: begin
				s.sda_oe = 1'b0;
				s.sda = 1'b1;
				s.delay_left = hold_delay(HOLD_1US, tpu);
			end
			PH_WA2: begin s.scl = 1'b1; s.delay_left = hold_delay(HOLD_1US, tpu); end
			default: ;
		endcase
		return s;
	endfunction

	function automatic phase_t next_phase(input phase_t p, input logic [3:0] bidx);
		phase_t n;
		case (p)
			PH_ST1:  n = PH_ST2;
			PH_ST2:  n = PH_ST3;
			PH_ST3:  n = PH_ST4;
			PH_ST4:  n = PH_SP1;
			PH_SP1:  n = PH_SP2;
			PH_SP2:  n = PH_SP3;
			PH_SP3:  n = PH_SP4;
			PH_SP4:  n = PH_WR0;
			PH_WR0:  n = PH_WR1;
			PH_WR1:  n = PH_WR2;
			PH_WR2:  n = PH_WR3;
			PH_WR3:  n = PH_WR1;
			PH_RD1:  n = PH_RD2;
			PH_RD2:  n = bidx[3] ? PH_AK1 : PH_RD1;
			PH_AK1:  n = PH_AK2;
			PH_AK2:  n = PH_AK3;
			PH_AK3:  n = PH_AK4;
			PH_AK4:  n = PH_WA1;
			PH_WA1:  n = PH_WA2;
			PH_WA2:  n = PH_WA3;
			default: n = PH_IDLE;
		endcase
		return n;
	endfunction

	function automatic state_t clear_cmd(input state_t st);
		state_t s;
		s = st;
		s.fail_pending = 1'b0;
		s.bit_index = 4'd0;
		s.poll_count = 16'd0;
		return s;
	endfunction

	state_t s;
	logic   done;
	logic   failed;
	logic   last;

	always_comb begin
		s = cur;
		done = 1'b0;
		failed = 1'b0;
		if (cur.phase == PH_IDLE) begin
			case (op)
				OP_START: s = apply(clear_cmd(s), PH_ST1, ticks_per_us);
				OP_STOP:  s = apply(clear_cmd(s), PH_SP1, ticks_per_us);
				OP_WRITE: begin
					s = clear_cmd(s);
					s.shift_byte = write_data;
					s = apply(s, PH_WR0, ticks_per_us);
				end
				OP_READ: begin
					s = clear_cmd(s);
					s.shift_byte = 8'd0;
					s.ack_choice = send_ack;
					s = apply(s, PH_RD1, ticks_per_us);
				end
				OP_WAIT_ACK: s = apply(clear_cmd(s), PH_WA1, ticks_per_us);
				default: ;
			endcase
		end else if (cur.delay_left != 11'd0) begin
			s.delay_left = cur.delay_left - 11'd1;
		end else begin
			if (cur.phase != PH_WA3)
				s = apply(s, next_phase(cur.phase, cur.bit_index), ticks_per_us);
			if (s.phase == PH_RD2) begin
				s.shift_byte = {s.shift_byte[6:0], sda_in};
				s.bit_index = s.bit_index + 4'd1;
				if (s.bit_index[3])
					s.rx_byte = s.shift_byte;
			end else if (s.phase == PH_WA3) begin
				if (!sda_in) begin
					s.scl = 1'b0;
					s.phase = PH_IDLE;
					done = 1'b1;
				end else if (s.poll_count >= ack_timeout) begin
					s.fail_pending = 1'b1;
					s = apply(s, PH_SP1, ticks_per_us);
				end else begin
					s.poll_count = s.poll_count + 16'd1;
				end
			end
		end

		last = (s.phase == PH_ST4) || (s.phase == PH_SP4) || (s.phase == PH_AK4) ||
			((s.phase == PH_WR3) && s.bit_index[3]);
		if ((s.phase != PH_IDLE) && (s.delay_left == 11'd0) && last) begin
			if (s.phase == PH_SP4) begin
				failed = s.fail_pending;
				s.fail_pending = 1'b0;
			end
			s.phase = PH_IDLE;
			done = 1'b1;
		end
	end

	assign nxt = s;
	assign res = '{
		scl_level:   s.scl,
		sda_level:   s.sda,
		sda_driving: s.sda_oe,
		busy_res:    (s.phase != PH_IDLE),
		done_res:    done,
		read_data:   s.rx_byte,
		ack_failed:  failed
	};

endmodule

/* rtl/i2c_master_bit_engine_top.sv */
// i2c_master_bit_engine_top: i2c master bit engine with command and result channels
// Every accepted command word is one bus tick; the engine takes one word per clock cycle
// and returns exactly one result word for it in the cycle after, in order. The whole tick
// (phase sequencing, hold countdown, byte shifting, ack polling) is one pass of logic
// from the state registers into the next state and the result register, so the rate is
// one word per cycle as long as the result side takes its words. The result register
// stalls the command side only while it holds a word that the result side refuses.
// An op given while the engine is busy, or an unused op code, is a plain tick.
// Configuration (ticks_per_us, ack_timeout) is written through its own channel, which
// is always ready, and is meant to change only while the engine is idle.
module i2c_master_bit_engine_top import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  write_data,
	input  logic        send_ack,
	input  logic        sda_in,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic        scl_level,
	output logic        sda_level,
	output logic        sda_driving,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_failed,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	state_t      state_q;
	state_t      state_nxt;
	res_t        res_nxt;
	res_t        res_q;
	logic        res_valid_q;
	logic [7:0]  ticks_per_us_q;
	logic [15:0] ack_timeout_q;
	logic        cmd_take;

	// a word waiting in the result register and refused holds the command side
	assign cmd_stall = res_valid_q & res_stall;
	assign cmd_take  = cmd_valid & ~cmd_stall;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_us_q <= TICKS_PER_US_RST;
			ack_timeout_q  <= ACK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TICKS_PER_US: ticks_per_us_q <= cfg_data[7:0];
				CFG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// one bus tick of next-state logic
	i2cm_step u_step (
		.cur          (state_q),
		.ticks_per_us (ticks_per_us_q),
		.ack_timeout  (ack_timeout_q),
		.op           (op),
		.write_data   (write_data),
		.send_ack     (send_ack),
		.sda_in       (sda_in),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// bus state advances only on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= STATE_RST;
		else if (cmd_take)
			state_q <= state_nxt;
	end

	// result register: refilled on accept, emptied when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd_take)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd_take)
			res_q <= res_nxt;
	end

	assign res_valid   = res_valid_q;
	assign scl_level   = res_q.scl_level;
	assign sda_level   = res_q.sda_level;
	assign sda_driving = res_q.sda_driving;
	assign busy_res    = res_q.busy_res;
	assign done_res    = res_q.done_res;
	assign read_data   = res_q.read_data;
	assign ack_failed  = res_q.ack_failed;

endmodule
